// File: sv/udp_source_admission_filter_macros.svh
// assertion macros for the udp source admission filter
// no dependencies; included by the top level
`ifndef UDP_SOURCE_ADMISSION_FILTER_MACROS_SVH
`define UDP_SOURCE_ADMISSION_FILTER_MACROS_SVH

// same-cycle implication
`define USAF_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("usaf assertion failed");

// next-cycle implication
`define USAF_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("usaf assertion failed");

`endif

// File: sv/usaf_pkg.sv
// types, constants and hash helpers for the udp source admission filter
// no dependencies
`timescale 1ns / 1ps

package usaf_pkg;

    localparam int          MAGIC_SLOTS      = 8;
    localparam int          MAX_DECAY_SHIFT  = 8;
    localparam logic [7:0]  UDP_PROTO        = 8'd17;
    localparam logic [63:0] DECAY_NS         = 64'd60000000000;
    localparam logic [15:0] FAIL_THR_RST     = 16'd100;
    localparam logic [15:0] RATE_LIMIT_RST   = 16'd10000;
    localparam logic [63:0] RATE_WINDOW_RST  = 64'd1000000000;
    localparam logic [31:0] MIX_C1           = 32'h7feb352d;
    localparam logic [31:0] MIX_C2           = 32'h846ca68b;

    typedef enum logic [2:0] {
        R_NOT_TARGET = 3'd0,
        R_NOT_UDP    = 3'd1,
        R_BLACKLIST  = 3'd2,
        R_RATE       = 3'd3,
        R_SHORT      = 3'd4,
        R_CACHE      = 3'd5,
        R_MAGIC_OK   = 3'd6,
        R_BAD_MAGIC  = 3'd7
    } t_reason;

    typedef enum logic [2:0] {
        REG_MAGIC0  = 3'd0,
        REG_MAGIC1  = 3'd1,
        REG_MAGIC2  = 3'd2,
        REG_MAGIC3  = 3'd3,
        REG_LISTEN  = 3'd4,
        REG_FAILTHR = 3'd5,
        REG_RATELIM = 3'd6,
        REG_WINDOW  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] arrival_time;
        logic        is_ipv4;
        logic        ip_header_present;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic        udp_header_present;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        payload_header_present;
        logic [31:0] magic_word;
    } t_item;

    typedef struct packed {
        logic       drop;
        logic [2:0] verdict_reason;
    } t_result;

    typedef struct packed {
        logic [3:0][63:0] magic_pair;
        logic [15:0]      listen_port;
        logic [15:0]      fail_threshold;
        logic [15:0]      rate_limit_packets;
        logic [63:0]      win_len_ns;
    } t_cfg;

    // one classified packet handed from the hash front end to the table stage
    typedef struct packed {
        t_item       item;
        logic        target;
        t_reason     reason;
        logic [31:0] bslot;
        logic [31:0] rslot;
        logic [31:0] cslot;
    } t_job;

    typedef enum logic [3:0] {
        F_IDLE, F_H1, F_H2, F_BQ, F_BR, F_RQ, F_RR, F_CQ,
        F_CR, F_C1, F_C2, F_C3, F_C4, F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_CLEAR, B_IDLE, B_RD, B_CMP, B_DEC
    } t_bstate;

    function automatic logic [31:0] mix_a(input logic [31:0] x);
        mix_a = x ^ (x >> 16);
    endfunction

    function automatic logic [31:0] mix_b(input logic [31:0] x);
        mix_b = x ^ (x >> 15);
    endfunction

endpackage

// File: sv/usaf_front.sv
// front end: accepts and classifies packets, computes table slots with one
// shared multiplier; depends on usaf_pkg
`timescale 1ns / 1ps

module usaf_front #(
    parameter int BLOCK_DEPTH = 1024,
    parameter int RATE_DEPTH  = 1024,
    parameter int CONN_DEPTH  = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  usaf_pkg::t_item    i_item,
    input  logic [15:0]        i_listen_port,
    output logic               o_busy,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output usaf_pkg::t_job     o_job
);

    // reciprocals for the modulo reductions
    localparam logic [31:0] DB = 32'(BLOCK_DEPTH);
    localparam logic [31:0] DR = 32'(RATE_DEPTH);
    localparam logic [31:0] DC = 32'(CONN_DEPTH);
    localparam logic [31:0] RB = 32'((64'd1 << 32) / BLOCK_DEPTH);
    localparam logic [31:0] RR = 32'((64'd1 << 32) / RATE_DEPTH);
    localparam logic [31:0] RC = 32'((64'd1 << 32) / CONN_DEPTH);

    usaf_pkg::t_fstate r_state, n_state;
    usaf_pkg::t_item   r_item;
    logic              r_target;
    usaf_pkg::t_reason r_reason;
    logic [31:0]       r_m, r_h, r_q, r_r, r_v, r_bs, r_rs;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod;
    logic [31:0]       lo;

    function automatic logic [31:0] fold(input logic [31:0] r, input logic [31:0] d);
        fold = (r >= d) ? r - d : r;
    endfunction

    function automatic logic target_of(input usaf_pkg::t_item it);
        target_of = it.is_ipv4 && it.ip_header_present &&
                    (it.ip_protocol == usaf_pkg::UDP_PROTO) &&
                    it.udp_header_present && (it.dest_port == i_listen_port);
    endfunction

    assign lo = {r_item.source_port, r_item.dest_port};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            usaf_pkg::F_IDLE: begin
                if (i_accept) begin
                    n_state = target_of(i_item) ? usaf_pkg::F_H1 : usaf_pkg::F_PUSH;
                end
            end
            usaf_pkg::F_H1:   n_state = usaf_pkg::F_H2;
            usaf_pkg::F_H2:   n_state = usaf_pkg::F_BQ;
            usaf_pkg::F_BQ:   n_state = usaf_pkg::F_BR;
            usaf_pkg::F_BR:   n_state = usaf_pkg::F_RQ;
            usaf_pkg::F_RQ:   n_state = usaf_pkg::F_RR;
            usaf_pkg::F_RR:   n_state = usaf_pkg::F_CQ;
            usaf_pkg::F_CQ:   n_state = usaf_pkg::F_CR;
            usaf_pkg::F_CR:   n_state = usaf_pkg::F_C1;
            usaf_pkg::F_C1:   n_state = usaf_pkg::F_C2;
            usaf_pkg::F_C2:   n_state = usaf_pkg::F_C3;
            usaf_pkg::F_C3:   n_state = usaf_pkg::F_C4;
            usaf_pkg::F_C4:   n_state = usaf_pkg::F_PUSH;
            usaf_pkg::F_PUSH: begin
                if (i_job_ready) begin
                    n_state = usaf_pkg::F_IDLE;
                end
            end
            default:          n_state = usaf_pkg::F_IDLE;
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            usaf_pkg::F_H1: begin
                mul_a = usaf_pkg::mix_a(r_item.source_address);
                mul_b = usaf_pkg::MIX_C1;
            end
            usaf_pkg::F_H2: begin
                mul_a = usaf_pkg::mix_b(r_m);
                mul_b = usaf_pkg::MIX_C2;
            end
            usaf_pkg::F_BQ: begin
                mul_a = usaf_pkg::mix_a(r_m);
                mul_b = RB;
            end
            usaf_pkg::F_BR: begin
                mul_a = r_q;
                mul_b = DB;
            end
            usaf_pkg::F_RQ: begin
                mul_a = r_h;
                mul_b = RR;
            end
            usaf_pkg::F_RR: begin
                mul_a = r_q;
                mul_b = DR;
            end
            usaf_pkg::F_CQ: begin
                mul_a = lo ^ r_h;
                mul_b = RC;
            end
            usaf_pkg::F_CR: begin
                mul_a = r_q;
                mul_b = DC;
            end
            usaf_pkg::F_C1: begin
                mul_a = usaf_pkg::mix_a(fold(r_r, DC) ^ lo);
                mul_b = usaf_pkg::MIX_C1;
            end
            usaf_pkg::F_C2: begin
                mul_a = usaf_pkg::mix_b(r_m);
                mul_b = usaf_pkg::MIX_C2;
            end
            usaf_pkg::F_C3: begin
                mul_a = usaf_pkg::mix_a(r_m);
                mul_b = RC;
            end
            usaf_pkg::F_C4: begin
                mul_a = r_q;
                mul_b = DC;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = {32'b0, mul_a} * {32'b0, mul_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= usaf_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            usaf_pkg::F_IDLE: begin
                if (i_accept) begin
                    r_item   <= i_item;
                    r_target <= target_of(i_item);
                    if (!i_item.is_ipv4 || !i_item.ip_header_present) begin
                        r_reason <= usaf_pkg::R_NOT_TARGET;
                    end else if (i_item.ip_protocol != usaf_pkg::UDP_PROTO) begin
                        r_reason <= usaf_pkg::R_NOT_UDP;
                    end else begin
                        r_reason <= usaf_pkg::R_NOT_TARGET;
                    end
                end
            end
            usaf_pkg::F_H1: r_m <= prod[31:0];
            usaf_pkg::F_H2: r_m <= prod[31:0];
            usaf_pkg::F_BQ: begin
                r_h <= mul_a;
                r_q <= prod[63:32];
            end
            usaf_pkg::F_BR: r_r <= r_h - prod[31:0];
            usaf_pkg::F_RQ: begin
                r_bs <= fold(r_r, DB);
                r_q  <= prod[63:32];
            end
            usaf_pkg::F_RR: r_r <= r_h - prod[31:0];
            usaf_pkg::F_CQ: begin
                r_rs <= fold(r_r, DR);
                r_v  <= mul_a;
                r_q  <= prod[63:32];
            end
            usaf_pkg::F_CR: r_r <= r_v - prod[31:0];
            usaf_pkg::F_C1: r_m <= prod[31:0];
            usaf_pkg::F_C2: r_m <= prod[31:0];
            usaf_pkg::F_C3: begin
                r_v <= mul_a;
                r_q <= prod[63:32];
            end
            usaf_pkg::F_C4: r_r <= r_v - prod[31:0];
            default: ;
        endcase
    end

    assign o_busy       = (r_state != usaf_pkg::F_IDLE);
    assign o_job_valid  = (r_state == usaf_pkg::F_PUSH);
    assign o_job.item   = r_item;
    assign o_job.target = r_target;
    assign o_job.reason = r_reason;
    assign o_job.bslot  = r_bs;
    assign o_job.rslot  = r_rs;
    assign o_job.cslot  = fold(r_r, DC);

endmodule

// File: sv/usaf_queue.sv
// two-entry queue of classified packets between front end and table stage
// depends on usaf_pkg
`timescale 1ns / 1ps

module usaf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  usaf_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output usaf_pkg::t_job o_pop_job
);

    usaf_pkg::t_job r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_job    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule

// File: sv/usaf_back.sv
// table stage: block, rate and connection tables, verdict and update
// depends on usaf_pkg
`timescale 1ns / 1ps

module usaf_back #(
    parameter int BLOCK_DEPTH = 1024,
    parameter int RATE_DEPTH  = 1024,
    parameter int CONN_DEPTH  = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  usaf_pkg::t_job    i_job,
    input  usaf_pkg::t_cfg    i_cfg,
    output logic              o_clearing,
    output logic              o_result_valid,
    output usaf_pkg::t_result o_result
);

    localparam int BIDX_W = $clog2(BLOCK_DEPTH);
    localparam int RIDX_W = $clog2(RATE_DEPTH);
    localparam int CIDX_W = $clog2(CONN_DEPTH);
    localparam int MAX_BR = (BLOCK_DEPTH > RATE_DEPTH) ? BLOCK_DEPTH : RATE_DEPTH;
    localparam int MAX_D  = (MAX_BR > CONN_DEPTH) ? MAX_BR : CONN_DEPTH;
    localparam int CLR_W  = $clog2(MAX_D) + 1;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [15:0] cnt;
        logic [63:0] last;
    } t_bent;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [63:0] start;
        logic [15:0] cnt;
    } t_rent;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [31:0] magic;
    } t_cent;

    t_bent r_bmem [BLOCK_DEPTH];
    t_rent r_rmem [RATE_DEPTH];
    t_cent r_cmem [CONN_DEPTH];
    t_bent r_brd;
    t_rent r_rrd;
    t_cent r_crd;

    usaf_pkg::t_bstate r_state, n_state;
    usaf_pkg::t_job    r_job;
    logic [CLR_W-1:0]  r_clr;

    logic              r_bhit, r_rhit, r_inwin, r_chit, r_mok;
    logic [3:0]        r_sh, n_sh;
    logic              n_chit, n_mok;
    logic [63:0]       bdiff;
    logic [63:0]       key;
    logic [63:0]       now;

    logic [BIDX_W-1:0] bidx, b_waddr;
    logic [RIDX_W-1:0] ridx, r_waddr;
    logic [CIDX_W-1:0] cidx, c_waddr;
    logic              b_we, r_we, c_we;
    t_bent             b_wdata;
    t_rent             r_wdata;
    t_cent             c_wdata;
    usaf_pkg::t_result n_res;
    usaf_pkg::t_result r_res;
    logic              r_res_vld;

    logic [15:0]       cnt_d;
    logic              bl_drop, rate_drop, after, bad;

    assign bidx = r_job.bslot[BIDX_W-1:0];
    assign ridx = r_job.rslot[RIDX_W-1:0];
    assign cidx = r_job.cslot[CIDX_W-1:0];
    assign now  = r_job.item.arrival_time;
    assign key  = {r_job.item.source_address, r_job.item.source_port,
                   r_job.item.dest_port};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            usaf_pkg::B_CLEAR: begin
                if (r_clr == CLR_W'(MAX_D - 1)) begin
                    n_state = usaf_pkg::B_IDLE;
                end
            end
            usaf_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    n_state = usaf_pkg::B_RD;
                end
            end
            usaf_pkg::B_RD:  n_state = usaf_pkg::B_CMP;
            usaf_pkg::B_CMP: n_state = usaf_pkg::B_DEC;
            usaf_pkg::B_DEC: n_state = usaf_pkg::B_IDLE;
            default:         n_state = usaf_pkg::B_IDLE;
        endcase
    end

    // compare stage values
    assign bdiff = now - r_brd.last;
    always_comb begin
        n_sh = 4'd0;
        for (int k = 1; k <= usaf_pkg::MAX_DECAY_SHIFT; k++) begin
            if (bdiff >= 64'(k) * usaf_pkg::DECAY_NS) begin
                n_sh = n_sh + 4'd1;
            end
        end
        n_chit = r_crd.valid && (r_crd.key == key) &&
                 (r_crd.magic == r_job.item.magic_word);
        n_mok = 1'b0;
        for (int i = 0; i < usaf_pkg::MAGIC_SLOTS; i++) begin
            if (i_cfg.magic_pair[i / 2][(i % 2) * 32 +: 32] == r_job.item.magic_word) begin
                n_mok = 1'b1;
            end
        end
    end

    // decision and table updates
    always_comb begin
        cnt_d     = r_brd.cnt >> r_sh;
        bl_drop   = r_bhit && (cnt_d >= i_cfg.fail_threshold);
        rate_drop = !bl_drop && r_rhit && r_inwin &&
                    (r_rrd.cnt >= i_cfg.rate_limit_packets);
        after     = !bl_drop && !rate_drop;
        bad       = after && r_job.item.payload_header_present && !r_chit && !r_mok;

        n_res.drop           = 1'b0;
        n_res.verdict_reason = r_job.reason;
        if (r_job.target) begin
            priority if (bl_drop) begin
                n_res.drop           = 1'b1;
                n_res.verdict_reason = usaf_pkg::R_BLACKLIST;
            end else if (rate_drop) begin
                n_res.drop           = 1'b1;
                n_res.verdict_reason = usaf_pkg::R_RATE;
            end else if (!r_job.item.payload_header_present) begin
                n_res.drop           = 1'b1;
                n_res.verdict_reason = usaf_pkg::R_SHORT;
            end else if (r_chit) begin
                n_res.verdict_reason = usaf_pkg::R_CACHE;
            end else if (r_mok) begin
                n_res.verdict_reason = usaf_pkg::R_MAGIC_OK;
            end else begin
                n_res.drop           = 1'b1;
                n_res.verdict_reason = usaf_pkg::R_BAD_MAGIC;
            end
        end

        b_wdata.valid = 1'b1;
        b_wdata.addr  = r_job.item.source_address;
        b_wdata.last  = now;
        if (!bad) begin
            b_wdata.cnt = cnt_d;
        end else if (!r_bhit) begin
            b_wdata.cnt = 16'd1;
        end else if (cnt_d == 16'hFFFF) begin
            b_wdata.cnt = cnt_d;
        end else begin
            b_wdata.cnt = cnt_d + 16'd1;
        end

        r_wdata.valid = 1'b1;
        r_wdata.addr  = r_job.item.source_address;
        if (r_rhit && r_inwin) begin
            r_wdata.start = r_rrd.start;
            r_wdata.cnt   = r_rrd.cnt + 16'd1;
        end else begin
            r_wdata.start = now;
            r_wdata.cnt   = 16'd1;
        end

        c_wdata.valid = 1'b1;
        c_wdata.key   = key;
        c_wdata.magic = r_job.item.magic_word;

        b_waddr = bidx;
        r_waddr = ridx;
        c_waddr = cidx;
        b_we    = 1'b0;
        r_we    = 1'b0;
        c_we    = 1'b0;
        unique case (r_state)
            usaf_pkg::B_CLEAR: begin
                b_wdata = '0;
                r_wdata = '0;
                c_wdata = '0;
                b_waddr = r_clr[BIDX_W-1:0];
                r_waddr = r_clr[RIDX_W-1:0];
                c_waddr = r_clr[CIDX_W-1:0];
                b_we    = (r_clr < CLR_W'(BLOCK_DEPTH));
                r_we    = (r_clr < CLR_W'(RATE_DEPTH));
                c_we    = (r_clr < CLR_W'(CONN_DEPTH));
            end
            usaf_pkg::B_DEC: begin
                b_we = r_job.target && ((r_bhit && (r_sh != 4'd0)) || bad);
                r_we = r_job.target && after;
                c_we = r_job.target && after && r_job.item.payload_header_present &&
                       !r_chit && r_mok;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= usaf_pkg::B_CLEAR;
            r_clr     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= (r_state == usaf_pkg::B_DEC);
            if (r_state == usaf_pkg::B_CLEAR) begin
                r_clr <= r_clr + CLR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == usaf_pkg::B_IDLE && i_job_valid) begin
            r_job <= i_job;
        end
        if (r_state == usaf_pkg::B_CMP) begin
            r_bhit  <= r_brd.valid && (r_brd.addr == r_job.item.source_address);
            r_rhit  <= r_rrd.valid && (r_rrd.addr == r_job.item.source_address);
            r_inwin <= ((now - r_rrd.start) < i_cfg.win_len_ns);
            r_sh    <= n_sh;
            r_chit  <= n_chit;
            r_mok   <= n_mok;
        end
        r_res <= n_res;
    end

    // table memories, registered read
    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_bmem[b_waddr] <= b_wdata;
        end
        r_brd <= r_bmem[bidx];
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_rmem[r_waddr] <= r_wdata;
        end
        r_rrd <= r_rmem[ridx];
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_cmem[c_waddr] <= c_wdata;
        end
        r_crd <= r_cmem[cidx];
    end

    assign o_job_ready    = (r_state == usaf_pkg::B_IDLE);
    assign o_clearing     = (r_state == usaf_pkg::B_CLEAR);
    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

endmodule

// File: sv/udp_source_admission_filter.sv
// top level of the udp source admission filter: register file and wiring
// depends on usaf_pkg, usaf_front, usaf_queue, usaf_back and the macro header
//
//  channel   direction  handshake                        payload
//  item      in         start high, busy low             i_item (t_item)
//  result    out        o_result_valid, one cycle        o_result (t_result)
//  config    in/out     apb, psel penable pwrite pready  paddr, pwdata, prdata
//
//  an item for the listen port passes the hash and reduction states of the
//  front end, whose one shared 32x32 multiplier computes the hashes and the
//  reductions for the three slots; other items go straight to push. the table
//  stage (read, compare, update) works in parallel through a two-entry queue.
//  after reset a clearing pass over max(BLOCK_DEPTH, RATE_DEPTH, CONN_DEPTH)
//  addresses holds busy high. results cannot be held off by the receiver.
`timescale 1ns / 1ps
`include "udp_source_admission_filter_macros.svh"

module udp_source_admission_filter #(
    parameter int BLOCK_DEPTH = 1024,
    parameter int RATE_DEPTH  = 1024,
    parameter int CONN_DEPTH  = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  usaf_pkg::t_item   i_item,
    output logic              o_result_valid,
    output usaf_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    usaf_pkg::t_cfg   r_cfg;
    usaf_pkg::t_reg_idx widx;
    logic             front_busy, clearing, accept;
    logic             job_valid, job_ready, q_valid, q_ready;
    usaf_pkg::t_job   job, q_job;
    logic             pass_reason;

    assign pready = 1'b1;
    assign widx   = usaf_pkg::t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_pair         <= '0;
            r_cfg.listen_port        <= '0;
            r_cfg.fail_threshold     <= usaf_pkg::FAIL_THR_RST;
            r_cfg.rate_limit_packets <= usaf_pkg::RATE_LIMIT_RST;
            r_cfg.win_len_ns         <= usaf_pkg::RATE_WINDOW_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (widx)
                usaf_pkg::REG_MAGIC0:  r_cfg.magic_pair[0]      <= pwdata;
                usaf_pkg::REG_MAGIC1:  r_cfg.magic_pair[1]      <= pwdata;
                usaf_pkg::REG_MAGIC2:  r_cfg.magic_pair[2]      <= pwdata;
                usaf_pkg::REG_MAGIC3:  r_cfg.magic_pair[3]      <= pwdata;
                usaf_pkg::REG_LISTEN:  r_cfg.listen_port        <= pwdata[15:0];
                usaf_pkg::REG_FAILTHR: r_cfg.fail_threshold     <= pwdata[15:0];
                usaf_pkg::REG_RATELIM: r_cfg.rate_limit_packets <= pwdata[15:0];
                usaf_pkg::REG_WINDOW:  r_cfg.win_len_ns         <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            usaf_pkg::REG_MAGIC0:  prdata = r_cfg.magic_pair[0];
            usaf_pkg::REG_MAGIC1:  prdata = r_cfg.magic_pair[1];
            usaf_pkg::REG_MAGIC2:  prdata = r_cfg.magic_pair[2];
            usaf_pkg::REG_MAGIC3:  prdata = r_cfg.magic_pair[3];
            usaf_pkg::REG_LISTEN:  prdata = {48'b0, r_cfg.listen_port};
            usaf_pkg::REG_FAILTHR: prdata = {48'b0, r_cfg.fail_threshold};
            usaf_pkg::REG_RATELIM: prdata = {48'b0, r_cfg.rate_limit_packets};
            usaf_pkg::REG_WINDOW:  prdata = r_cfg.win_len_ns;
            default:               prdata = '0;
        endcase
    end

    assign busy   = front_busy || clearing;
    assign accept = start && !busy;

    usaf_front #(
        .BLOCK_DEPTH (BLOCK_DEPTH),
        .RATE_DEPTH  (RATE_DEPTH),
        .CONN_DEPTH  (CONN_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_item),
        .i_listen_port (r_cfg.listen_port),
        .o_busy        (front_busy),
        .o_job_valid   (job_valid),
        .i_job_ready   (job_ready),
        .o_job         (job)
    );

    usaf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (job_valid),
        .o_push_ready (job_ready),
        .i_push_job   (job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_job    (q_job)
    );

    usaf_back #(
        .BLOCK_DEPTH (BLOCK_DEPTH),
        .RATE_DEPTH  (RATE_DEPTH),
        .CONN_DEPTH  (CONN_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .o_job_ready    (q_ready),
        .i_job          (q_job),
        .i_cfg          (r_cfg),
        .o_clearing     (clearing),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    assign pass_reason = (o_result.verdict_reason == usaf_pkg::R_NOT_TARGET) ||
                         (o_result.verdict_reason == usaf_pkg::R_NOT_UDP) ||
                         (o_result.verdict_reason == usaf_pkg::R_CACHE) ||
                         (o_result.verdict_reason == usaf_pkg::R_MAGIC_OK);

    // a result from the table stage is never followed directly by another result
    `USAF_ASSERT_NXT(a_result_spacing, i_clk, i_rst_n, o_result_valid, !o_result_valid)
    // an accepted item always makes the front end busy
    `USAF_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, start && !busy, busy)
    // passing reasons never come with a drop
    `USAF_ASSERT_IMP(a_pass_reasons, i_clk, i_rst_n, o_result_valid && pass_reason, !o_result.drop)

endmodule
